FILE: design/autoranging_light_level_bar_assert.svh
// Assertion macros shared by the autoranging light level bar design.
`ifndef AUTORANGING_LIGHT_LEVEL_BAR_ASSERT_SVH
`define AUTORANGING_LIGHT_LEVEL_BAR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ALB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/alb_pkg.sv
package alb_pkg;

   localparam int unsigned LEVELS      = 5;
   localparam int unsigned SAMPLE_BITS = 12;

   localparam int unsigned SAMPLE_W = SAMPLE_BITS;
   localparam int unsigned LEVEL_W  = 3;
   localparam int unsigned BAR_W    = 5;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned RANGE_W  = 12;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned ADDR_W   = 3;
   // Scaled numerator (sample - min) * LEVELS.
   localparam int unsigned NUM_W    = SAMPLE_W + $clog2(LEVELS + 1);
   localparam int unsigned STEP_W   = $clog2(NUM_W);

   localparam logic [COUNT_W-1:0] CALIB_RESET = COUNT_W'(2000);
   localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(300);
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};

   typedef enum logic {
      CSR_CALIB_SAMPLES = 1'b0,
      CSR_MIN_RANGE     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                learning;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] high;
   } marks_type;

   function automatic logic [BAR_W-1:0] thermometer(input logic [LEVEL_W-1:0] lvl);
      logic [BAR_W-1:0] code;
      code = '0;
      for (int i = 0; i < BAR_W; i++) begin
         code[i] = (LEVEL_W'(i) < lvl);
      end
      return code;
   endfunction

endpackage

FILE: design/alb_calib.sv
module alb_calib (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [alb_pkg::SAMPLE_W-1:0]     sample,
   input  logic [alb_pkg::COUNT_W-1:0]      calib_samples,
   output alb_pkg::marks_type               marks
);

   logic [alb_pkg::SAMPLE_W-1:0] low_ff, low_in;
   logic [alb_pkg::SAMPLE_W-1:0] high_ff, high_in;
   logic [alb_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         learning_ff, learning_in;
   logic                         learn_now;

   // The count stops at calib_samples, so the increment never wraps.
   assign learn_now = count_ff < calib_samples;

   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      count_in    = count_ff;
      learning_in = learning_ff;
      if (take) begin
         learning_in = learn_now;
         if (learn_now) begin
            if (sample < low_ff) begin
               low_in = sample;
            end
            if (sample > high_ff) begin
               high_in = sample;
            end
            count_in = count_ff + alb_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= alb_pkg::FULL_SCALE;
         high_ff     <= '0;
         count_ff    <= '0;
         learning_ff <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         count_ff    <= count_in;
         learning_ff <= learning_in;
      end
   end

   assign marks.learning = learning_ff;
   assign marks.low      = low_ff;
   assign marks.high     = high_ff;

endmodule

FILE: design/alb_div.sv
module alb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [alb_pkg::NUM_W-1:0]     numer,
   input  logic [alb_pkg::SAMPLE_W-1:0]  divisor,
   output logic                          busy,
   output logic [alb_pkg::NUM_W-1:0]     quot
);

   logic                          busy_ff, busy_in;
   logic [alb_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [alb_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [alb_pkg::SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [alb_pkg::SAMPLE_W-1:0]  div_ff, div_in;
   logic [alb_pkg::SAMPLE_W:0]    trial;
   logic [alb_pkg::SAMPLE_W+1:0]  diff;
   logic                          fits;

   // Restoring division: one numerator bit enters the remainder per cycle,
   // and the quotient bit takes its place at the bottom of the same register.
   assign trial = {rem_ff, quo_ff[alb_pkg::NUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_ff};
   assign fits  = ~diff[alb_pkg::SAMPLE_W+1];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = alb_pkg::STEP_W'(alb_pkg::NUM_W - 1);
         quo_in  = numer;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[alb_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? diff[alb_pkg::SAMPLE_W-1:0] : trial[alb_pkg::SAMPLE_W-1:0];
         step_in = step_ff - alb_pkg::STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

FILE: design/autoranging_light_level_bar.sv
// Autoranging light level bar graph.
// Input channel req_ (req_valid, req_ready, req_sample) takes one 12-bit
// light sensor reading per item. Result channel rsp_ gives one item per
// reading: the level from 0 to 5, a thermometer bar code, the calibrating
// flag and the learned minimum and maximum after that reading.
// The csr_ port is an APB-style port: calib_samples at address 0 and
// min_range at address 4; writes land when psel, penable and pwrite are high.
// The reading is registered and the span and the scaled numerator are formed
// from it; the bit-serial divider then retires one quotient bit per cycle over
// a 15-bit numerator and hands its result over to the output register.
// No new reading is taken until the previous result has left the divider,
// which holds one item at a time.
// Reset clears the learned minimum to full scale, the maximum and the sample
// count to zero and restores both registers to their reset values.
// If the receiver stalls, the finished item waits in the output register and
// the block still takes the next reading; that reading's result then waits
// in the divider until the output register is free.
`include "autoranging_light_level_bar_assert.svh"

module autoranging_light_level_bar (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [alb_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [alb_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [alb_pkg::BAR_W-1:0]           rsp_bar,
   output logic                                rsp_calibrating,
   output logic [alb_pkg::SAMPLE_W-1:0]        rsp_learned_min,
   output logic [alb_pkg::SAMPLE_W-1:0]        rsp_learned_max,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [alb_pkg::ADDR_W-1:0]          paddr,
   input  logic [alb_pkg::CSR_W-1:0]           pwdata,
   output logic [alb_pkg::CSR_W-1:0]           prdata,
   output logic                                pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV
   } state_type;

   state_type                       state_ff, state_in;

   // Configuration registers.
   logic [alb_pkg::COUNT_W-1:0]     calib_ff, calib_in;
   logic [alb_pkg::RANGE_W-1:0]     range_ff, range_in;
   alb_pkg::csr_index_type          csr_index;
   logic                            csr_write;

   // Held reading and the datapath towards the divider.
   logic [alb_pkg::SAMPLE_W-1:0]    sample_ff, sample_in;
   logic                            take;
   alb_pkg::marks_type              marks;
   logic [alb_pkg::SAMPLE_W-1:0]    spread;
   logic [alb_pkg::SAMPLE_W-1:0]    bound;
   logic [alb_pkg::SAMPLE_W-1:0]    span;
   logic [alb_pkg::SAMPLE_W-1:0]    above;
   logic [alb_pkg::NUM_W-1:0]       numer;
   logic                            div_start;
   logic                            div_busy;
   logic [alb_pkg::NUM_W-1:0]       quot;
   logic [alb_pkg::LEVEL_W-1:0]     level;

   // Output register.
   logic                            out_valid_ff, out_valid_in;
   logic [alb_pkg::LEVEL_W-1:0]     out_level_ff, out_level_in;
   logic [alb_pkg::BAR_W-1:0]       out_bar_ff, out_bar_in;
   logic                            out_calib_ff, out_calib_in;
   logic [alb_pkg::SAMPLE_W-1:0]    out_min_ff, out_min_in;
   logic [alb_pkg::SAMPLE_W-1:0]    out_max_ff, out_max_in;
   logic                            out_free;
   logic                            finish;

   // Register file: the word address picks the register, byte offsets are ignored.
   assign pready    = 1'b1;
   assign csr_index = alb_pkg::csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      calib_in = calib_ff;
      range_in = range_ff;
      if (csr_write) begin
         unique case (csr_index)
            alb_pkg::CSR_CALIB_SAMPLES: calib_in = pwdata[alb_pkg::COUNT_W-1:0];
            alb_pkg::CSR_MIN_RANGE:     range_in = pwdata[alb_pkg::RANGE_W-1:0];
            default:                    calib_in = calib_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         alb_pkg::CSR_CALIB_SAMPLES:
            prdata = alb_pkg::CSR_W'(calib_ff);
         alb_pkg::CSR_MIN_RANGE:
            prdata = alb_pkg::CSR_W'(range_ff);
         default:
            prdata = '0;
      endcase
   end

   // A reading is taken only while the datapath is free; the output register
   // may still hold the previous result at that time.
   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign sample_in = take ? req_sample : sample_ff;

   alb_calib u_calib (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .sample        (req_sample),
      .calib_samples (calib_ff),
      .marks         (marks)
   );

   // Span: maximum minus minimum, zero when no reading has been learned yet,
   // then raised to min_range, with a zero min_range counting as one.
   always_comb begin
      spread = (marks.high >= marks.low) ? (marks.high - marks.low) : '0;
      bound  = (range_ff == '0) ? alb_pkg::SAMPLE_W'(1) : range_ff;
      span   = (spread < bound) ? bound : spread;
      // A reading at or below the minimum gives a zero numerator, so level 0.
      above  = (sample_ff > marks.low) ? (sample_ff - marks.low) : '0;
      numer  = alb_pkg::NUM_W'(above) * alb_pkg::NUM_W'(alb_pkg::LEVELS);
   end

   assign div_start = (state_ff == ST_LOAD);

   alb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (numer),
      .divisor (span),
      .busy    (div_busy),
      .quot    (quot)
   );

   // The quotient saturates at the top level.
   assign level = (quot > alb_pkg::NUM_W'(alb_pkg::LEVELS)) ?
                  alb_pkg::LEVEL_W'(alb_pkg::LEVELS) : quot[alb_pkg::LEVEL_W-1:0];

   assign out_free = !out_valid_ff || rsp_ready;
   assign finish   = (state_ff == ST_DIV) && !div_busy && out_free;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_level_in = out_level_ff;
      out_bar_in   = out_bar_ff;
      out_calib_in = out_calib_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         out_valid_in = 1'b1;
         out_level_in = level;
         out_bar_in   = alb_pkg::thermometer(level);
         out_calib_in = marks.learning;
         out_min_in   = marks.low;
         out_max_in   = marks.high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         calib_ff     <= alb_pkg::CALIB_RESET;
         range_ff     <= alb_pkg::RANGE_RESET;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         calib_ff     <= calib_in;
         range_ff     <= range_in;
      end
      sample_ff    <= sample_in;
      out_level_ff <= out_level_in;
      out_bar_ff   <= out_bar_in;
      out_calib_ff <= out_calib_in;
      out_min_ff   <= out_min_in;
      out_max_ff   <= out_max_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_level       = out_level_ff;
   assign rsp_bar         = out_bar_ff;
   assign rsp_calibrating = out_calib_ff;
   assign rsp_learned_min = out_min_ff;
   assign rsp_learned_max = out_max_ff;

   // Once a reading is taken, no other is taken until its result is out.
   `ALB_ASSERT_NEXT(a_one_in_flight, clock, reset, take, !req_ready)
   // Loading the divider always starts it.
   `ALB_ASSERT_NEXT(a_div_starts, clock, reset, state_ff == ST_LOAD, div_busy)
   // The bar always matches the level it is shown with.
   `ALB_ASSERT_NOW(a_bar_matches, clock, reset, rsp_valid,
      rsp_bar == alb_pkg::thermometer(rsp_level))
   // A reading that took part in learning leaves the minimum at or below the maximum.
   `ALB_ASSERT_NOW(a_marks_ordered, clock, reset, rsp_valid && rsp_calibrating,
      rsp_learned_min <= rsp_learned_max)

endmodule
